// File: rtl/core/oldel_pkg.sv
// Package for the ordered list delete engine: command and status codes,
// the controller state type and the command/status structs between the
// controller and the datapath. Depends on nothing.
`default_nettype none

package oldel_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;
    localparam int LEN_W        = 5;

    typedef enum logic [2:0] {
        CMD_CLEAR     = 3'd0,
        CMD_APPEND    = 3'd1,
        CMD_DEL_FIRST = 3'd2,
        CMD_DEL_VALUE = 3'd3,
        CMD_DEL_LAST  = 3'd4,
        CMD_DISPLAY   = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        WALK_NONE,
        WALK_SEARCH,
        WALK_SHIFT,
        WALK_DISP
    } t_walk;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_DISP,
        S_RESULT
    } t_state;

    typedef struct packed {
        t_walk   mode;
        logic    start_walk;
        logic    start_last;
        logic    match_any;
        logic    clear_cnt;
        logic    append;
        logic    dec_cnt;
        logic    load_res;
        logic    use_val;
        t_status res_status;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic found;
        logic miss;
        logic shift_done;
        logic disp_last;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// File: rtl/core/oldel_dp.sv
// Datapath of the ordered list delete engine: entry memory, entry count,
// walk pointer with registered read, and the output register.
// Depends on oldel_pkg.
`default_nettype none

module oldel_dp #(
    parameter int CAPACITY = oldel_pkg::CAPACITY_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  oldel_pkg::t_dp_cmd                   i_cmd,
    output oldel_pkg::t_dp_sts                   o_sts,
    input  logic signed [oldel_pkg::DATA_W-1:0]  i_operand_value,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic signed [oldel_pkg::DATA_W-1:0]  o_result_value,
    output logic [1:0]                           o_status,
    output logic                                 o_last_of_run,
    output logic [oldel_pkg::LEN_W-1:0]          o_list_length
);
    import oldel_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [DATA_W-1:0] r_mem [0:CAPACITY-1];
    logic [DATA_W-1:0] r_rdata;

    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_ptr, n_ptr;
    logic [CW-1:0]     r_cidx, n_cidx;
    logic              r_rvalid, n_rvalid;
    logic [DATA_W-1:0] r_opv, n_opv;
    logic              r_any, n_any;
    logic [DATA_W-1:0] r_val, n_val;

    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_out_value, n_out_value;
    logic [1:0]        r_out_status, n_out_status;
    logic              r_out_last, n_out_last;
    logic [LEN_W-1:0]  r_out_len, n_out_len;

    logic              out_free;
    logic              match;
    logic              ptr_live;
    logic              last_idx;
    logic              rd_issue;
    logic              consume;
    logic              load_disp;
    logic              load_res;
    logic              wr_en;
    logic [AW-1:0]     waddr;
    logic [DATA_W-1:0] wdata;
    logic [CW-1:0]     cidx_inc;
    logic [CW-1:0]     cidx_dec;
    logic [CW+LEN_W-1:0] count_ext;

    always_comb begin
        out_free  = !r_out_valid || i_out_ready;
        match     = r_rvalid && (r_any || (r_rdata == r_opv));
        ptr_live  = r_ptr < r_count;
        cidx_inc  = r_cidx + CW'(1);
        cidx_dec  = r_cidx - CW'(1);
        last_idx  = cidx_inc == r_count;
        count_ext = {{LEN_W{1'b0}}, n_count};

        case (i_cmd.mode)
            WALK_SEARCH: begin
                rd_issue = ptr_live && !match;
                consume  = 1'b1;
            end
            WALK_SHIFT: begin
                rd_issue = ptr_live;
                consume  = 1'b1;
            end
            WALK_DISP: begin
                rd_issue = ptr_live && (!r_rvalid || out_free);
                consume  = out_free;
            end
            default: begin
                rd_issue = 1'b0;
                consume  = 1'b0;
            end
        endcase

        load_disp = (i_cmd.mode == WALK_DISP) && r_rvalid && out_free;
        load_res  = i_cmd.load_res && out_free;

        wr_en = i_cmd.append || ((i_cmd.mode == WALK_SHIFT) && r_rvalid);
        waddr = i_cmd.append ? r_count[AW-1:0] : cidx_dec[AW-1:0];
        wdata = i_cmd.append ? i_operand_value : r_rdata;
    end

    always_comb begin
        n_ptr    = r_ptr;
        n_cidx   = r_cidx;
        n_rvalid = r_rvalid;
        n_opv    = r_opv;
        n_any    = r_any;
        n_val    = r_val;
        n_count  = r_count;

        if (rd_issue) begin
            n_ptr    = r_ptr + CW'(1);
            n_cidx   = r_ptr;
            n_rvalid = 1'b1;
        end else if (consume) begin
            n_rvalid = 1'b0;
        end

        if ((i_cmd.mode == WALK_SEARCH) && match) begin
            n_ptr    = cidx_inc;
            n_rvalid = 1'b0;
            n_val    = r_rdata;
        end

        if (i_cmd.start_walk) begin
            n_ptr    = i_cmd.start_last ? (r_count - CW'(1)) : '0;
            n_rvalid = 1'b0;
            n_opv    = i_operand_value;
            n_any    = i_cmd.match_any;
        end

        if (i_cmd.clear_cnt) begin
            n_count = '0;
        end else if (i_cmd.append) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.dec_cnt) begin
            n_count = r_count - CW'(1);
        end
    end

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        n_out_len    = r_out_len;

        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (load_disp) begin
            n_out_valid  = 1'b1;
            n_out_value  = r_rdata;
            n_out_status = ST_OK;
            n_out_last   = last_idx;
            n_out_len    = count_ext[LEN_W-1:0];
        end else if (load_res) begin
            n_out_valid  = 1'b1;
            n_out_value  = i_cmd.use_val ? r_val : '0;
            n_out_status = i_cmd.res_status;
            n_out_last   = 1'b1;
            n_out_len    = count_ext[LEN_W-1:0];
        end
    end

    always_comb begin
        o_sts.empty      = r_count == '0;
        o_sts.full       = r_count == CW'(CAPACITY);
        o_sts.found      = (i_cmd.mode == WALK_SEARCH) && match;
        o_sts.miss       = (i_cmd.mode == WALK_SEARCH) && r_rvalid && !match && last_idx;
        o_sts.shift_done = (i_cmd.mode == WALK_SHIFT) && !ptr_live && !r_rvalid;
        o_sts.disp_last  = load_disp && last_idx;
        o_sts.out_free   = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[waddr] <= wdata;
        end
        if (rd_issue) begin
            r_rdata <= r_mem[r_ptr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ptr       <= '0;
            r_rvalid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_ptr       <= n_ptr;
            r_rvalid    <= n_rvalid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cidx       <= n_cidx;
        r_opv        <= n_opv;
        r_any        <= n_any;
        r_val        <= n_val;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
        r_out_len    <= n_out_len;
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_status       = r_out_status;
    assign o_last_of_run  = r_out_last;
    assign o_list_length  = r_out_len;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("Entry count above capacity.");

    a_append_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.append |-> (r_count < CW'(CAPACITY)))
        else $error("Append issued on a full list.");

    a_dec_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.dec_cnt |-> (r_count != '0))
        else $error("Entry count decremented below zero.");

    a_shift_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((i_cmd.mode == WALK_SHIFT) && r_rvalid) |-> (r_cidx != '0))
        else $error("Gap closing wrote below the first entry.");

endmodule

`default_nettype wire

// File: rtl/core/oldel_ctrl.sv
// Controller state machine of the ordered list delete engine: decodes the
// command of each item and sequences the datapath walks and the result.
// Depends on oldel_pkg.
`default_nettype none

module oldel_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_command,
    input  oldel_pkg::t_dp_sts i_sts,
    output oldel_pkg::t_dp_cmd o_cmd
);
    import oldel_pkg::*;

    t_state  r_state, n_state;
    t_status r_res_status, n_res_status;
    logic    r_use_val, n_use_val;
    logic    accept;

    assign accept = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_res_status = r_res_status;
        n_use_val    = r_use_val;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_use_val = 1'b0;
                    case (t_cmd'(i_command))
                        CMD_CLEAR: begin
                            n_res_status = ST_OK;
                            n_state      = S_RESULT;
                        end
                        CMD_APPEND: begin
                            n_res_status = i_sts.full ? ST_FULL : ST_OK;
                            n_state      = S_RESULT;
                        end
                        CMD_DEL_FIRST, CMD_DEL_VALUE, CMD_DEL_LAST: begin
                            if (i_sts.empty) begin
                                n_res_status = ST_EMPTY;
                                n_state      = S_RESULT;
                            end else begin
                                n_state = S_SEARCH;
                            end
                        end
                        CMD_DISPLAY: begin
                            if (i_sts.empty) begin
                                n_res_status = ST_EMPTY;
                                n_state      = S_RESULT;
                            end else begin
                                n_state = S_DISP;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (i_sts.found) begin
                    n_res_status = ST_OK;
                    n_use_val    = 1'b1;
                    n_state      = S_SHIFT;
                end else if (i_sts.miss) begin
                    n_res_status = ST_NOTFOUND;
                    n_use_val    = 1'b0;
                    n_state      = S_RESULT;
                end
            end
            S_SHIFT: begin
                if (i_sts.shift_done) begin
                    n_state = S_RESULT;
                end
            end
            S_DISP: begin
                if (i_sts.disp_last) begin
                    n_state = S_IDLE;
                end
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = r_state == S_IDLE;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (t_cmd'(i_command))
                        CMD_CLEAR: begin
                            o_cmd.clear_cnt = 1'b1;
                        end
                        CMD_APPEND: begin
                            o_cmd.append = !i_sts.full;
                        end
                        CMD_DEL_FIRST: begin
                            o_cmd.start_walk = 1'b1;
                            o_cmd.match_any  = 1'b1;
                        end
                        CMD_DEL_VALUE: begin
                            o_cmd.start_walk = 1'b1;
                        end
                        CMD_DEL_LAST: begin
                            o_cmd.start_walk = 1'b1;
                            o_cmd.start_last = 1'b1;
                            o_cmd.match_any  = 1'b1;
                        end
                        CMD_DISPLAY: begin
                            o_cmd.start_walk = 1'b1;
                        end
                        default: begin
                            o_cmd = '0;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                o_cmd.mode = WALK_SEARCH;
            end
            S_SHIFT: begin
                o_cmd.mode    = WALK_SHIFT;
                o_cmd.dec_cnt = i_sts.shift_done;
            end
            S_DISP: begin
                o_cmd.mode = WALK_DISP;
            end
            S_RESULT: begin
                o_cmd.load_res   = 1'b1;
                o_cmd.use_val    = r_use_val;
                o_cmd.res_status = r_res_status;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_status <= n_res_status;
        r_use_val    <= n_use_val;
    end

endmodule

`default_nettype wire

// File: rtl/core/ordered_list_delete_engine_unit.sv
// Ordered list delete engine: top level joining the controller and datapath; depends on
// oldel_pkg, oldel_ctrl and oldel_dp. Clear and append go straight to the result load; the
// deletes search the list (delete last starts at its last entry) and, on a hit, close the
// gap before the result is loaded; display loads one item per cycle while the output is
// free. The input is ready again the cycle after the final result is loaded, and output
// stalls delay it. Reset is synchronous and empties the list.
`default_nettype none

module ordered_list_delete_engine_unit #(
    parameter int CAPACITY = oldel_pkg::CAPACITY_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [2:0]                           i_command,
    input  logic signed [oldel_pkg::DATA_W-1:0]  i_operand_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [oldel_pkg::DATA_W-1:0]  o_result_value,
    output logic [1:0]                           o_status,
    output logic                                 o_last_of_run,
    output logic [oldel_pkg::LEN_W-1:0]          o_list_length
);
    import oldel_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    oldel_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_command  (i_command),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    oldel_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_sts           (dp_sts),
        .i_operand_value (i_operand_value),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_result_value  (o_result_value),
        .o_status        (o_status),
        .o_last_of_run   (o_last_of_run),
        .o_list_length   (o_list_length)
    );

endmodule

`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for the ordered list delete engine: queued command items
// are driven on the input channel and every result item is checked in order against
// a list predictor. Depends on oldel_pkg and ordered_list_delete_engine_unit.
`timescale 1ns / 1ps

module testbench;
    import oldel_pkg::*;

    localparam int CAPACITY    = CAPACITY_DEF;
    localparam int QUIET_LIMIT = 3000;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 40;

    typedef struct {
        logic [2:0]         cmd;
        logic signed [31:0] opv;
        int                 phase;
        bit                 drain;
    } cmd_item_t;

    typedef struct {
        logic signed [31:0] value;
        t_status            status;
        logic               last;
        logic [4:0]         len;
    } list_result_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic [2:0]         i_command = '0;
    logic signed [31:0] i_operand_value = '0;
    logic               out_ready = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic signed [31:0] o_result_value;
    logic [1:0]         o_status;
    logic               o_last_of_run;
    logic [4:0]         o_list_length;

    cmd_item_t          pending_cmds[$];
    list_result_t       expected_results[$];
    logic signed [31:0] list_entries[CAPACITY];
    int                 list_count = 0;
    int                 results_outstanding = 0;
    int                 cur_phase = 0;
    int                 mismatches = 0;
    int                 cmds_taken = 0;
    int                 hold_left = 0;
    int                 quiet_cycles = 0;
    bit                 drain_next = 0;
    int                 counted_cmds = 0;
    logic signed [31:0] recent_values[$];

    ordered_list_delete_engine_unit #(.CAPACITY(CAPACITY)) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_operand_value (i_operand_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_result_value  (o_result_value),
        .o_status        (o_status),
        .o_last_of_run   (o_last_of_run),
        .o_list_length   (o_list_length)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic signed [31:0] take_entry(input int pos);
        logic signed [31:0] v;
        v = list_entries[pos];
        for (int i = pos; i + 1 < list_count; i++) begin
            list_entries[i] = list_entries[i + 1];
        end
        list_count--;
        return v;
    endfunction

    task automatic apply_list_command(input logic [2:0] cmd, input logic signed [31:0] opv);
        list_result_t r;
        int hit;
        r.value = '0;
        r.status = ST_OK;
        r.last = 1'b1;
        hit = -1;
        case (t_cmd'(cmd))
            CMD_CLEAR: list_count = 0;
            CMD_APPEND: begin
                if (list_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    list_entries[list_count] = opv;
                    list_count++;
                end
            end
            CMD_DEL_FIRST: begin
                if (list_count == 0) r.status = ST_EMPTY;
                else r.value = take_entry(0);
            end
            CMD_DEL_VALUE: begin
                if (list_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    for (int i = 0; i < list_count; i++) begin
                        if (hit < 0 && list_entries[i] == opv) hit = i;
                    end
                    if (hit < 0) r.status = ST_NOTFOUND;
                    else r.value = take_entry(hit);
                end
            end
            CMD_DEL_LAST: begin
                if (list_count == 0) r.status = ST_EMPTY;
                else r.value = take_entry(list_count - 1);
            end
            CMD_DISPLAY: begin
                if (list_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    for (int i = 0; i + 1 < list_count; i++) begin
                        expected_results.push_back('{list_entries[i], ST_OK, 1'b0,
                                                     5'(list_count)});
                    end
                    r.value = list_entries[list_count - 1];
                end
            end
            default: return;
        endcase
        r.len = 5'(list_count);
        expected_results.push_back(r);
    endtask

    task automatic add_cmd(input logic [2:0] cmd, input logic signed [31:0] opv);
        pending_cmds.push_back('{cmd, opv, 0, drain_next});
        drain_next = 0;
        counted_cmds++;
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return $urandom_range(7);
            3: return -$signed(32'($urandom_range(7)));
            default: return $urandom;
        endcase
    endfunction

    function automatic int sender_idle_pct(input int phase);
        return (phase == 0) ? 22 : (phase == 1) ? 58 : 0;
    endfunction

    function automatic int receiver_idle_pct(input int phase);
        return (phase == 0) ? 58 : (phase == 1) ? 22 : 0;
    endfunction

    always @(posedge i_clk) begin : drive
        logic fire;
        logic load;
        cmd_item_t nxt;
        fire = in_valid && o_in_ready;
        load = 1'b0;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || fire) begin
            if (pending_cmds.size() != 0) begin
                if (pending_cmds[0].drain) begin
                    load = !fire && results_outstanding == 0;
                end else begin
                    load = $urandom_range(99) >= sender_idle_pct(pending_cmds[0].phase);
                end
            end
            if (load) begin
                nxt = pending_cmds.pop_front();
                i_command <= nxt.cmd;
                i_operand_value <= nxt.opv;
                cur_phase <= nxt.phase;
            end
            in_valid <= load;
        end
    end

    always @(posedge i_clk) begin : monitor
        list_result_t exp;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result item: value %0d status %0d",
                           o_result_value, o_status);
                    mismatches++;
                end else begin
                    exp = expected_results.pop_front();
                    if (o_result_value !== exp.value) begin
                        $error("result_value: expected %0d, got %0d", exp.value, o_result_value);
                        mismatches++;
                    end
                    if (o_status !== exp.status) begin
                        $error("status: expected %0d, got %0d", exp.status, o_status);
                        mismatches++;
                    end
                    if (o_last_of_run !== exp.last) begin
                        $error("last_of_run: expected %0d, got %0d", exp.last, o_last_of_run);
                        mismatches++;
                    end
                    if (o_list_length !== exp.len) begin
                        $error("list_length: expected %0d, got %0d", exp.len, o_list_length);
                        mismatches++;
                    end
                end
            end
            if (in_valid && o_in_ready) begin
                apply_list_command(i_command, i_operand_value);
                cmds_taken++;
                if (cmds_taken == 20 || cmds_taken == 110) hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= $urandom_range(99) >= receiver_idle_pct(cur_phase);
            end
            results_outstanding <= expected_results.size();
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin : stimulus
        int n;
        int k;
        logic signed [31:0] v;

        add_cmd(CMD_DISPLAY, 0);
        add_cmd(CMD_DEL_FIRST, 0);
        add_cmd(CMD_DEL_VALUE, 32'sh8000_0000);
        add_cmd(CMD_DEL_LAST, 0);
        add_cmd(3'd7, 32'sh7fff_ffff);
        add_cmd(CMD_APPEND, 32'sh8000_0000);
        add_cmd(CMD_APPEND, 32'sh7fff_ffff);
        add_cmd(CMD_APPEND, 0);
        add_cmd(CMD_APPEND, -1);
        add_cmd(CMD_APPEND, 32'sh5555_5555);
        add_cmd(CMD_APPEND, 32'shaaaa_aaaa);
        add_cmd(CMD_APPEND, 0);
        for (int i = 0; i < CAPACITY - 7; i++) add_cmd(CMD_APPEND, 1000 + i);
        add_cmd(CMD_APPEND, 77);
        add_cmd(CMD_DISPLAY, 0);
        add_cmd(CMD_DEL_VALUE, 12345);
        add_cmd(CMD_DEL_VALUE, 0);
        add_cmd(CMD_DEL_FIRST, 0);
        add_cmd(CMD_DEL_LAST, 0);
        add_cmd(CMD_CLEAR, 0);

        drain_next = 1;
        while (counted_cmds < 120) begin
            if ($urandom_range(9) < 7) begin
                if ($urandom_range(6) == 0) drain_next = 1;
                if ($urandom_range(2) == 0) add_cmd(CMD_CLEAR, pick_value());
                n = ($urandom_range(3) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 10);
                repeat (n) begin
                    v = pick_value();
                    recent_values.push_back(v);
                    if (recent_values.size() > CAPACITY) void'(recent_values.pop_front());
                    add_cmd(CMD_APPEND, v);
                end
                k = $urandom_range(1, n + 2);
                repeat (k) begin
                    case ($urandom_range(5))
                        0: add_cmd(CMD_DEL_FIRST, pick_value());
                        1: add_cmd(CMD_DEL_LAST, pick_value());
                        2, 3: begin
                            if ($urandom_range(4) != 0)
                                v = recent_values[$urandom_range(recent_values.size() - 1)];
                            else
                                v = pick_value();
                            add_cmd(CMD_DEL_VALUE, v);
                        end
                        4: add_cmd(CMD_DISPLAY, pick_value());
                        default: add_cmd(CMD_APPEND, pick_value());
                    endcase
                end
                add_cmd(CMD_DISPLAY, pick_value());
            end else begin
                repeat ($urandom_range(2, 6)) add_cmd(3'($urandom_range(7)), pick_value());
            end
        end
        for (int i = 0; i < pending_cmds.size(); i++) begin
            pending_cmds[i].phase = i * 3 / pending_cmds.size();
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk); while (pending_cmds.size() != 0 || in_valid);
        do @(posedge i_clk); while (results_outstanding != 0);
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
